@@ rtl/power_of_d_bin_balancer_defines.svh @@
// ---------------------------------------------------------------------------
// Power-of-d bin balancer assertion macros
// Concurrent check helpers used by the top-level RTL file.
// ---------------------------------------------------------------------------
`ifndef POWER_OF_D_BIN_BALANCER_DEFINES_SVH
`define POWER_OF_D_BIN_BALANCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PBB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pbb_pkg.sv @@
// ---------------------------------------------------------------------------
// Power-of-d bin balancer package
// Field widths, register indexes, defaults and controller/datapath types.
// ---------------------------------------------------------------------------
package pbb_pkg;

    localparam int CAND_W      = 10;
    localparam int LOAD_OUT_W  = 16;
    localparam int BINS_W      = 11;
    localparam int CHOICES_W   = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;
    localparam int CAND_FIELDS = 4;
    localparam int CAND_SEL_W  = 2;
    localparam int K_W         = 3;

    localparam int MAX_BINS_DEF    = 1024;
    localparam int MAX_CHOICES_DEF = 4;
    localparam int LOAD_BITS_DEF   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHOICES  = 1'd1;

    localparam logic [BINS_W-1:0]    NUM_BINS_RST = 11'd1024;
    localparam logic [CHOICES_W-1:0] CHOICES_RST  = 3'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_UPDATE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic first_rd;
        logic set_err;
        logic step_rd;
        logic update;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic bad;
        logic more;
        logic out_free;
    } t_dp_sts;

endpackage

@@ rtl/pbb_cand_if.sv @@
// ---------------------------------------------------------------------------
// Candidate channel
// Valid/ready channel carrying the four candidate bin indices of one ball.
// ---------------------------------------------------------------------------
interface pbb_cand_if;
    logic                      valid;
    logic                      ready;
    logic [pbb_pkg::CAND_W-1:0] cand_a;
    logic [pbb_pkg::CAND_W-1:0] cand_b;
    logic [pbb_pkg::CAND_W-1:0] cand_c;
    logic [pbb_pkg::CAND_W-1:0] cand_d;

    modport source (output valid, cand_a, cand_b, cand_c, cand_d, input ready);
    modport sink   (input valid, cand_a, cand_b, cand_c, cand_d, output ready);
endinterface

@@ rtl/pbb_res_if.sv @@
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the placement result of one ball.
// ---------------------------------------------------------------------------
interface pbb_res_if;
    logic                          valid;
    logic                          ready;
    logic [pbb_pkg::CAND_W-1:0]     chosen_bin;
    logic [pbb_pkg::LOAD_OUT_W-1:0] new_load;
    logic [pbb_pkg::LOAD_OUT_W-1:0] max_load;
    logic [pbb_pkg::BINS_W-1:0]     empty_bins;
    logic                          error;

    modport source (output valid, chosen_bin, new_load, max_load, empty_bins, error,
                    input ready);
    modport sink   (input valid, chosen_bin, new_load, max_load, empty_bins, error,
                    output ready);
endinterface

@@ rtl/pbb_ctrl.sv @@
// ---------------------------------------------------------------------------
// Power-of-d bin balancer controller
// Sequences the clearing pass, range check, candidate reads and write-back.
// ---------------------------------------------------------------------------
module pbb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  pbb_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output pbb_pkg::t_dp_cmd o_cmd
);

    pbb_pkg::t_state r_state;
    pbb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pbb_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pbb_pkg::ST_CLEAR: begin
                if (i_sts.clr_last) n_state = pbb_pkg::ST_IDLE;
            end
            pbb_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = pbb_pkg::ST_CHECK;
            end
            pbb_pkg::ST_CHECK: begin
                n_state = i_sts.bad ? pbb_pkg::ST_OUT : pbb_pkg::ST_READ;
            end
            pbb_pkg::ST_READ: begin
                if (!i_sts.more) n_state = pbb_pkg::ST_UPDATE;
            end
            pbb_pkg::ST_UPDATE: begin
                n_state = pbb_pkg::ST_OUT;
            end
            pbb_pkg::ST_OUT: begin
                if (i_sts.out_free) n_state = pbb_pkg::ST_IDLE;
            end
            default: begin
                n_state = pbb_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_in_ready      = (r_state == pbb_pkg::ST_IDLE);
        o_cmd.clr_step  = (r_state == pbb_pkg::ST_CLEAR);
        o_cmd.accept    = (r_state == pbb_pkg::ST_IDLE) && i_in_valid;
        o_cmd.first_rd  = (r_state == pbb_pkg::ST_CHECK) && !i_sts.bad;
        o_cmd.set_err   = (r_state == pbb_pkg::ST_CHECK) && i_sts.bad;
        o_cmd.step_rd   = (r_state == pbb_pkg::ST_READ);
        o_cmd.update    = (r_state == pbb_pkg::ST_UPDATE);
        o_cmd.load_out  = (r_state == pbb_pkg::ST_OUT) && i_sts.out_free;
    end

endmodule

@@ rtl/pbb_dp.sv @@
// ---------------------------------------------------------------------------
// Power-of-d bin balancer datapath
// Load memory, candidate compare, counters, configuration and result register.
// ---------------------------------------------------------------------------
module pbb_dp #(
    parameter int MAX_BINS    = pbb_pkg::MAX_BINS_DEF,
    parameter int MAX_CHOICES = pbb_pkg::MAX_CHOICES_DEF,
    parameter int LOAD_BITS   = pbb_pkg::LOAD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pbb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pbb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [pbb_pkg::CAND_W-1:0]      i_cand_a,
    input  logic [pbb_pkg::CAND_W-1:0]      i_cand_b,
    input  logic [pbb_pkg::CAND_W-1:0]      i_cand_c,
    input  logic [pbb_pkg::CAND_W-1:0]      i_cand_d,
    input  pbb_pkg::t_dp_cmd                i_cmd,
    output pbb_pkg::t_dp_sts                o_sts,
    pbb_res_if.source                       o_res
);

    localparam int BIN_W     = $clog2(MAX_BINS);
    localparam int OCC_W     = $clog2(MAX_BINS + 1);
    localparam int CMP_W     = (OCC_W > pbb_pkg::BINS_W) ? OCC_W : pbb_pkg::BINS_W;
    localparam int BINS_CAP  = (MAX_BINS < 2047) ? MAX_BINS : 2047;
    localparam int CH_CAP    = (MAX_CHOICES < pbb_pkg::CAND_FIELDS) ?
                               MAX_CHOICES : pbb_pkg::CAND_FIELDS;
    localparam logic [LOAD_BITS-1:0] LOAD_LIMIT = '1;

    logic [LOAD_BITS-1:0] r_mem [MAX_BINS];

    logic [pbb_pkg::BINS_W-1:0]    r_num_bins;
    logic [pbb_pkg::CHOICES_W-1:0] r_choices;
    logic [pbb_pkg::CAND_W-1:0]    r_cand [pbb_pkg::CAND_FIELDS];
    logic [pbb_pkg::CHOICES_W-1:0] r_d;
    logic [pbb_pkg::K_W-1:0]       r_k;
    logic [BIN_W-1:0]              r_clr_addr;
    logic [LOAD_BITS-1:0]          r_rd_data;
    logic [pbb_pkg::CAND_W-1:0]    r_best;
    logic [LOAD_BITS-1:0]          r_best_load;
    logic [LOAD_BITS-1:0]          r_peak;
    logic [OCC_W-1:0]              r_occ;
    logic [pbb_pkg::CAND_W-1:0]    r_res_bin;
    logic [LOAD_BITS-1:0]          r_res_load;
    logic                          r_res_err;
    logic                          r_out_valid;

    logic [pbb_pkg::BINS_W-1:0]    w_n_eff;
    logic [pbb_pkg::CHOICES_W-1:0] w_d_eff;
    logic                          w_bad;
    logic [pbb_pkg::CAND_W-1:0]    w_rd_cand;
    logic [pbb_pkg::CAND_W-1:0]    w_prev_cand;
    logic [pbb_pkg::K_W-1:0]       w_prev_k;
    logic                          w_take;
    logic [LOAD_BITS-1:0]          w_new_load;
    logic [pbb_pkg::BINS_W-1:0]    w_empty;
    logic                          w_out_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_bins <= pbb_pkg::NUM_BINS_RST;
            r_choices  <= pbb_pkg::CHOICES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pbb_pkg::CFG_NUM_BINS: r_num_bins <= i_cfg_data;
                pbb_pkg::CFG_CHOICES:  r_choices  <= i_cfg_data[pbb_pkg::CHOICES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_n_eff = (r_num_bins > pbb_pkg::BINS_W'(BINS_CAP)) ?
                  pbb_pkg::BINS_W'(BINS_CAP) : r_num_bins;
        priority if (r_choices == '0) begin
            w_d_eff = pbb_pkg::CHOICES_W'(1);
        end else if (r_choices > pbb_pkg::CHOICES_W'(CH_CAP)) begin
            w_d_eff = pbb_pkg::CHOICES_W'(CH_CAP);
        end else begin
            w_d_eff = r_choices;
        end
    end

    // Range check over the used candidates
    always_comb begin
        w_bad = 1'b0;
        for (int i = 0; i < pbb_pkg::CAND_FIELDS; i++) begin
            if ((pbb_pkg::CHOICES_W'(i) < r_d) &&
                (pbb_pkg::BINS_W'(r_cand[i]) >= w_n_eff)) begin
                w_bad = 1'b1;
            end
        end
    end

    assign w_rd_cand   = r_cand[r_k[pbb_pkg::CAND_SEL_W-1:0]];
    assign w_prev_k    = r_k - pbb_pkg::K_W'(1);
    assign w_prev_cand = r_cand[w_prev_k[pbb_pkg::CAND_SEL_W-1:0]];
    assign w_take      = (r_rd_data < r_best_load) ||
                         ((r_rd_data == r_best_load) && (w_prev_cand < r_best));
    assign w_new_load  = (r_best_load == LOAD_LIMIT) ? r_best_load :
                         r_best_load + LOAD_BITS'(1);
    assign w_empty     = (CMP_W'(r_occ) >= CMP_W'(w_n_eff)) ? '0 :
                         pbb_pkg::BINS_W'(CMP_W'(w_n_eff) - CMP_W'(r_occ));
    assign w_out_free  = !r_out_valid || o_res.ready;

    always_comb begin
        o_sts.clr_last = (r_clr_addr == BIN_W'(MAX_BINS - 1));
        o_sts.bad      = w_bad;
        o_sts.more     = ({1'b0, r_k} < {1'b0, r_d});
        o_sts.out_free = w_out_free;
    end

    // Load memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.update) begin
            r_mem[BIN_W'(r_best)] <= w_new_load;
        end
        r_rd_data <= r_mem[BIN_W'(w_rd_cand)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step && !o_sts.clr_last) begin
            r_clr_addr <= r_clr_addr + BIN_W'(1);
        end
    end

    // Item capture and candidate walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cand[0] <= i_cand_a;
            r_cand[1] <= i_cand_b;
            r_cand[2] <= i_cand_c;
            r_cand[3] <= i_cand_d;
            r_d       <= w_d_eff;
        end
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_cmd.accept) begin
            r_k <= '0;
        end else if (i_cmd.first_rd || (i_cmd.step_rd && o_sts.more)) begin
            r_k <= r_k + pbb_pkg::K_W'(1);
        end
        if (i_cmd.step_rd) begin
            if (w_prev_k == '0 || w_take) begin
                r_best      <= w_prev_cand;
                r_best_load <= r_rd_data;
            end
        end
    end

    // Running statistics and pending result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
            r_occ  <= '0;
        end else if (i_cmd.update) begin
            if (r_best_load == '0) r_occ <= r_occ + OCC_W'(1);
            if (w_new_load > r_peak) r_peak <= w_new_load;
        end
        if (i_cmd.set_err) begin
            r_res_bin  <= '0;
            r_res_load <= '0;
            r_res_err  <= 1'b1;
        end else if (i_cmd.update) begin
            r_res_bin  <= r_best;
            r_res_load <= w_new_load;
            r_res_err  <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            o_res.chosen_bin <= r_res_bin;
            o_res.new_load   <= pbb_pkg::LOAD_OUT_W'(r_res_load);
            o_res.max_load   <= pbb_pkg::LOAD_OUT_W'(r_peak);
            o_res.empty_bins <= w_empty;
            o_res.error      <= r_res_err;
        end
    end

    assign o_res.valid = r_out_valid;

endmodule

@@ rtl/power_of_d_bin_balancer.sv @@
// Flow: an accepted item is range checked, its candidates read and the best bin written back
//   before its result reaches the output register; an out-of-range item goes straight to
//   the output stage with its error flag set. A new item is taken only once the current
//   result is in the output register; candidate reads are serial through the single read port.
// Reset: synchronous, active low; clears control, statistics and configuration, then
//   runs a clearing pass over all MAX_BINS load memory entries with no item accepted.
// ---------------------------------------------------------------------------
// Power-of-d bin balancer
// Places each ball in the least loaded of up to four candidate bins.
// ---------------------------------------------------------------------------
`include "power_of_d_bin_balancer_defines.svh"

module power_of_d_bin_balancer #(
    parameter int MAX_BINS    = pbb_pkg::MAX_BINS_DEF,
    parameter int MAX_CHOICES = pbb_pkg::MAX_CHOICES_DEF,
    parameter int LOAD_BITS   = pbb_pkg::LOAD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pbb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pbb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pbb_cand_if.sink                       i_cand,
    pbb_res_if.source                      o_res
);

    pbb_pkg::t_dp_cmd w_cmd;
    pbb_pkg::t_dp_sts w_sts;
    logic             w_in_ready;

    pbb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cand.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    pbb_dp #(
        .MAX_BINS    (MAX_BINS),
        .MAX_CHOICES (MAX_CHOICES),
        .LOAD_BITS   (LOAD_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cand_a   (i_cand.cand_a),
        .i_cand_b   (i_cand.cand_b),
        .i_cand_c   (i_cand.cand_c),
        .i_cand_d   (i_cand.cand_d),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_res      (o_res)
    );

    assign i_cand.ready = w_in_ready;

    `PBB_ASSERT_NEXT(a_one_item, i_clk, i_rst_n,
                     i_cand.valid && i_cand.ready, !i_cand.ready,
                     "item accepted while another is in flight")
    `PBB_ASSERT_SAME(a_no_take_in_clear, i_clk, i_rst_n,
                     w_cmd.clr_step, !i_cand.ready,
                     "input ready during memory clearing pass")
    `PBB_ASSERT_SAME(a_load_when_free, i_clk, i_rst_n,
                     w_cmd.load_out, w_sts.out_free,
                     "result loaded over an untaken result")

endmodule
